FILE: rtl/pso_pkg.sv
// Shared constants and saturation helpers for the particle swarm update unit.
`timescale 1ns / 1ps

package pso_pkg;

    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 16;

    localparam logic [CfgIdxW-1:0] REG_INERTIA = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_COGNITIVE = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_SOCIAL = 2'd2;

    localparam logic CMD_INIT = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    // 2.0 in Q16.16
    localparam logic signed [32:0] TWO_Q16 = 33'sd131072;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // Saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [50:0] a);
        logic signed [31:0] r;
        if (a > 51'(S32_MAX))
            r = S32_MAX;
        else if (a < 51'(S32_MIN))
            r = S32_MIN;
        else
            r = a[31:0];
        return r;
    endfunction

    // Saturating unsigned 64-bit add
    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

endpackage

FILE: rtl/pso_particle_update_unit.sv
// Top level: one-particle swarm update, one dimension per transaction.
`timescale 1ns / 1ps
// Sequence: input transaction to result through read, gains, products, sum, squares,
//   write back and output; a new item is accepted once the result has been taken.
// Occupancy: one item at a time, set by the single-item sequencer over the memory
//   read and multiply chain and held by an output stall; a last item that replaces
//   the best also waits for the best-vector copy through the one read port.
// Reset: rst_n asynchronous active low clears sequencer, sums and index, configuration to defaults.

module pso_particle_update_unit #(
    parameter int MAX_DIM = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [pso_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [pso_pkg::CfgDataW-1:0] cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        cmd,
    input  logic signed [31:0]          global_best,
    input  logic signed [31:0]          lower_limit,
    input  logic signed [31:0]          upper_limit,
    input  logic [15:0]                 rand_one,
    input  logic [15:0]                 rand_two,
    input  logic                        last_element,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [31:0]          position,
    output logic signed [31:0]          speed,
    output logic [63:0]                 objective_one,
    output logic [63:0]                 objective_two,
    output logic                        best_replaced,
    output logic                        final_result
);

    localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_DIM - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL1, S_MUL2, S_SUM, S_SQ, S_WB, S_COPY, S_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic [15:0] inertia_reg, cognitive_reg, social_reg;

    // item registers
    logic              cmd_reg, last_reg;
    logic signed [31:0] gbest_reg, lo_reg, hi_reg;
    logic [15:0]       r1_reg, r2_reg;
    logic [AW-1:0]     idx_reg, copy_reg;

    // memories
    logic signed [31:0] pos_mem [MAX_DIM];
    logic signed [31:0] spd_mem [MAX_DIM];
    logic signed [31:0] best_mem [MAX_DIM];
    logic signed [31:0] pos_rd_reg, spd_rd_reg, best_rd_reg;
    logic [AW-1:0]      rd_addr;
    logic               pos_we, best_we;
    logic [AW-1:0]      pos_wa, best_wa;
    logic signed [31:0] best_wd;

    // datapath
    logic [15:0]        g1_reg, g2_reg;
    logic signed [49:0] t0_reg, t1_reg, t2_reg;
    logic signed [31:0] x_reg, v_reg;
    logic [63:0]        sum0_reg, sum1_reg, bo0_reg, bo1_reg;
    logic [63:0]        sq0_reg, sq1_reg;
    logic               repl_reg;

    // result register
    logic signed [31:0] position_reg, speed_reg;
    logic [63:0]        obj1_reg, obj2_reg;
    logic               out_valid_reg, brep_reg, fin_reg;

    logic in_acc, out_acc;
    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid_reg && !out_stall;
    assign in_stall = (state_reg != S_IDLE) || out_valid_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inertia_reg   <= 16'd2048;
            cognitive_reg <= 16'd8192;
            social_reg    <= 16'd8192;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pso_pkg::REG_INERTIA:   inertia_reg   <= cfg_data;
                pso_pkg::REG_COGNITIVE: cognitive_reg <= cfg_data;
                pso_pkg::REG_SOCIAL:    social_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // memory read address: the item's entry, or the copy pointer
    assign rd_addr = (state_reg == S_COPY) ? copy_reg : idx_reg;

    // memories, registered reads
    always_ff @(posedge clk)
    begin
        pos_rd_reg  <= pos_mem[rd_addr];
        spd_rd_reg  <= spd_mem[rd_addr];
        best_rd_reg <= best_mem[rd_addr];
        if (pos_we)
        begin
            pos_mem[pos_wa] <= x_reg;
            spd_mem[pos_wa] <= v_reg;
        end
        if (best_we)
            best_mem[best_wa] <= best_wd;
    end

    // copy write lands in the cycle after its read; the item's own write lands before the copy reads
    logic          copy_act_reg;
    logic [AW-1:0] copy_wa_reg;
    assign pos_we  = (state_reg == S_WB);
    assign pos_wa  = idx_reg;
    assign best_we = copy_act_reg;
    assign best_wa = copy_wa_reg;
    assign best_wd = pos_rd_reg;

    // velocity term products, Q.28
    logic signed [50:0] acc_sum;
    logic signed [38:0] acc_shr;
    logic signed [32:0] diff_b, diff_g;
    logic signed [33:0] span;
    logic signed [50:0] init_prod;
    logic signed [31:0] v_new, x_add, x_clamp, x_init;
    logic signed [32:0] xm2;
    assign diff_b = 33'(best_rd_reg) - 33'(pos_rd_reg);
    assign diff_g = 33'(gbest_reg) - 33'(pos_rd_reg);
    assign span   = 34'(hi_reg) - 34'(lo_reg);
    assign init_prod = 51'(span) * $signed({1'b0, r1_reg});
    assign x_init = pso_pkg::sat32(51'(lo_reg) + (init_prod >>> 16));
    assign acc_sum = 51'(t0_reg) + 51'(t1_reg) + 51'(t2_reg);
    assign acc_shr = 39'(acc_sum >>> 12);
    assign v_new = pso_pkg::sat32(51'(acc_shr));
    assign x_add = pso_pkg::sat32(51'(pos_rd_reg) + 51'(v_new));
    always_comb
    begin
        x_clamp = x_add;
        if (x_clamp < lo_reg)
            x_clamp = lo_reg;
        if (x_clamp > hi_reg)
            x_clamp = hi_reg;
    end
    assign xm2 = 33'(x_reg) - pso_pkg::TWO_Q16;

    logic [31:0] abs_x;
    logic [32:0] abs_xm2;
    assign abs_x   = x_reg[31] ? 32'(-33'(x_reg)) : 32'(x_reg);
    assign abs_xm2 = xm2[32] ? 33'(-34'(xm2)) : 33'(xm2);

    logic [63:0] n0, n1;
    logic        dom;
    assign n0  = pso_pkg::sat_add64(sum0_reg, sq0_reg);
    assign n1  = pso_pkg::sat_add64(sum1_reg, sq1_reg);
    assign dom = (bo0_reg <= n0) && (bo1_reg <= n1) && ((bo0_reg < n0) || (bo1_reg < n1));

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            copy_reg      <= '0;
            copy_act_reg  <= 1'b0;
            copy_wa_reg   <= '0;
            sum0_reg      <= '0;
            sum1_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            copy_act_reg <= 1'b0;
            if (out_acc)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        cmd_reg   <= cmd;
                        last_reg  <= last_element;
                        gbest_reg <= global_best;
                        lo_reg    <= lower_limit;
                        hi_reg    <= upper_limit;
                        r1_reg    <= rand_one;
                        r2_reg    <= rand_two;
                        state_reg <= S_MUL1;
                    end
                end
                S_MUL1:
                begin
                    // read data valid now; gains
                    g1_reg    <= 16'((32'(cognitive_reg) * 32'(r1_reg)) >> 16);
                    g2_reg    <= 16'((32'(social_reg) * 32'(r2_reg)) >> 16);
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    t0_reg    <= 50'($signed({1'b0, inertia_reg}) * spd_rd_reg);
                    t1_reg    <= 50'($signed({1'b0, g1_reg}) * diff_b);
                    t2_reg    <= 50'($signed({1'b0, g2_reg}) * diff_g);
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    if (cmd_reg == pso_pkg::CMD_UPDATE)
                    begin
                        x_reg <= x_clamp;
                        v_reg <= v_new;
                    end
                    else
                    begin
                        x_reg <= x_init;
                        v_reg <= '0;
                    end
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    sq0_reg   <= 64'(abs_x) * 64'(abs_x);
                    sq1_reg   <= 64'(abs_xm2) * 64'(abs_xm2);
                    state_reg <= S_WB;
                end
                S_WB:
                begin
                    position_reg <= x_reg;
                    speed_reg    <= v_reg;
                    fin_reg      <= last_reg;
                    if (last_reg)
                    begin
                        repl_reg <= (cmd_reg == pso_pkg::CMD_INIT) || !dom;
                        obj1_reg <= n0;
                        obj2_reg <= n1;
                        brep_reg <= (cmd_reg == pso_pkg::CMD_INIT) || !dom;
                        sum0_reg <= '0;
                        sum1_reg <= '0;
                        idx_reg  <= '0;
                        if ((cmd_reg == pso_pkg::CMD_INIT) || !dom)
                        begin
                            bo0_reg <= n0;
                            bo1_reg <= n1;
                        end
                    end
                    else
                    begin
                        obj1_reg <= '0;
                        obj2_reg <= '0;
                        brep_reg <= 1'b0;
                        repl_reg <= 1'b0;
                        sum0_reg <= n0;
                        sum1_reg <= n1;
                        idx_reg  <= (idx_reg == LAST_ADDR) ? '0 : idx_reg + 1'b1;
                    end
                    copy_wa_reg <= idx_reg;
                    copy_reg    <= '0;
                    state_reg   <= (last_reg && ((cmd_reg == pso_pkg::CMD_INIT) || !dom))
                                   ? S_COPY : S_OUT;
                end
                S_COPY:
                begin
                    // one entry a cycle; write address trails the read pointer
                    copy_act_reg <= 1'b1;
                    copy_wa_reg  <= copy_reg;
                    if (copy_reg == LAST_ADDR)
                        state_reg <= S_OUT;
                    else
                        copy_reg <= copy_reg + 1'b1;
                end
                S_OUT:
                begin
                    if (!copy_act_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign position      = position_reg;
    assign speed         = speed_reg;
    assign objective_one = obj1_reg;
    assign objective_two = obj2_reg;
    assign best_replaced = brep_reg;
    assign final_result  = fin_reg;

    // checks
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_acc) else $error("accept while busy");
    a_flags_off: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !fin_reg) |-> (!brep_reg && obj1_reg == '0)) else $error("flags");
    a_copy_only_repl: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COPY) |-> repl_reg) else $error("copy without replace");
    a_idx_zero_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && fin_reg) |-> (idx_reg == '0 && sum0_reg == '0))
        else $error("index not cleared");

endmodule
